// ===== rtl/adu_pkg.sv =====
// Shared types and constants for the Adadelta update block.
package adu_pkg;

    localparam int DEPTH_DEFAULT     = 4096;
    localparam int FRAC_BITS_DEFAULT = 16;
    localparam int IDX_W             = 12;
    localparam int PADDR_W           = 4;
    localparam int RATE_BITS         = 16;

    localparam logic [16:0] RATE_ONE = 17'h10000;

    localparam logic [16:0] DECAY_RATE_RESET   = 17'd62259;
    localparam logic [15:0] STABILIZER_RESET   = 16'd1;
    localparam logic [15:0] WEIGHT_DECAY_RESET = 16'd0;
    localparam logic [31:0] GRAD_SCALE_RESET   = 32'd65536;

    typedef enum logic [1:0] {
        REG_DECAY_RATE,
        REG_STABILIZER,
        REG_WEIGHT_DECAY,
        REG_GRAD_SCALE
    } reg_index_t;

    typedef struct packed {
        logic [IDX_W-1:0]   elem_index;
        logic signed [31:0] weight_in;
        logic signed [31:0] gradient_in;
    } update_req_t;

    typedef struct packed {
        logic [IDX_W-1:0]   elem_index_out;
        logic signed [31:0] weight_out;
    } update_rsp_t;

endpackage

// ===== rtl/adadelta_update.sv =====
// Top level of the pipelined Adadelta weight update with per-element accumulators.
//
// Channel   Signals                                   Moves
// config    psel penable pwrite paddr pwdata prdata   register reads and writes
// request   req_valid req_ready req_data              element index, weight, gradient
// response  rsp_valid rsp_ready rsp_data              element index, new weight
//
// One transaction enters per cycle unless held off (memory clear, hazard or full output
// buffer); the path to the response runs through the three address stages and the main
// pipeline, whose depth is set by the two bit-per-stage square roots and the 32-stage divider.
// After reset the accumulator memory is cleared, address by address, with req_ready low.
// A transaction whose element is still in flight waits in the last address stage
// until the earlier one has written its accumulators back.
// The pipeline stops only when the two-entry output buffer is full.
module adadelta_update #(
    parameter int DEPTH     = adu_pkg::DEPTH_DEFAULT,
    parameter int FRAC_BITS = adu_pkg::FRAC_BITS_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [adu_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    input  logic                         req_valid,
    output logic                         req_ready,
    input  adu_pkg::update_req_t         req_data,
    output logic                         rsp_valid,
    input  logic                         rsp_ready,
    output adu_pkg::update_rsp_t         rsp_data
);

    import adu_pkg::*;

    localparam int AW     = $clog2(DEPTH);
    localparam int RAD_W  = 33 + FRAC_BITS;
    localparam int RW     = (RAD_W + 1) / 2;
    localparam int NW     = 32 + RW;
    localparam int RECIP  = (1 << 24) / DEPTH;
    localparam int P_RD   = 1;
    localparam int P_G    = 2;
    localparam int P_G2   = 3;
    localparam int P_PB   = 4;
    localparam int P_SGA  = 5;
    localparam int P_SQ0  = 6;
    localparam int P_NUM  = P_SQ0 + RW;
    localparam int P_OVF  = P_NUM + 1;
    localparam int P_DLT  = P_OVF + 33;
    localparam int P_D2   = P_DLT + 1;
    localparam int P_PB2  = P_D2 + 1;
    localparam int P_FIN  = P_PB2 + 1;
    localparam int NS     = P_FIN + 1;

    typedef struct packed {
        logic [IDX_W-1:0]   idx;
        logic [IDX_W-1:0]   qd;
        logic [IDX_W-1:0]   rr;
        logic [AW-1:0]      addr;
        logic signed [31:0] w;
        logic [31:0]        grad;
        logic [31:0]        sga_old;
        logic [31:0]        sda_old;
        logic [63:0]        pg;
        logic [47:0]        wl;
        logic               gs;
        logic [31:0]        gm;
        logic signed [32:0] rg;
        logic [63:0]        g2;
        logic [48:0]        pa;
        logic [48:0]        pb;
        logic [31:0]        sga_new;
        logic [RAD_W-1:0]   rem_d;
        logic [RAD_W-1:0]   rem_n;
        logic [RW-1:0]      root_d;
        logic [RW-1:0]      root_n;
        logic [NW-1:0]      num;
        logic               ovf;
        logic               zden;
        logic [31:0]        quo;
        logic               ds;
        logic [31:0]        dm;
        logic [31:0]        sda_new;
        logic signed [31:0] wout;
    } item_t;

    logic [16:0] decay_rate_reg;
    logic [15:0] stabilizer_reg;
    logic [15:0] weight_decay_reg;
    logic [31:0] grad_scale_reg;
    logic [16:0] rho;
    logic [16:0] rho_inv;

    logic          clr_active_reg;
    logic [AW-1:0] clr_addr_reg;

    item_t f1_reg, f2_reg, f3_reg;
    logic  f1_valid_reg, f2_valid_reg, f3_valid_reg;
    item_t f1_next, f2_next, f3_next;

    item_t          pipe_reg [NS];
    item_t          stage_next [NS];
    logic [NS-1:0]  pipe_valid_reg;

    logic        hazard;
    logic        block;
    logic        back_en;
    logic        front_adv;
    logic        push;
    logic        take;
    logic [63:0] ram_rdata;
    logic        ram_we;
    logic [AW-1:0] ram_waddr;
    logic [63:0] ram_wdata;

    update_rsp_t rsp_data_reg;
    update_rsp_t skid_data_reg;
    update_rsp_t push_data;
    logic        rsp_valid_reg;
    logic        skid_valid_reg;

    // Configuration port.
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decay_rate_reg   <= DECAY_RATE_RESET;
            stabilizer_reg   <= STABILIZER_RESET;
            weight_decay_reg <= WEIGHT_DECAY_RESET;
            grad_scale_reg   <= GRAD_SCALE_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            case (reg_index_t'(paddr[3:2]))
                REG_DECAY_RATE:   decay_rate_reg   <= pwdata[16:0];
                REG_STABILIZER:   stabilizer_reg   <= pwdata[15:0];
                REG_WEIGHT_DECAY: weight_decay_reg <= pwdata[15:0];
                REG_GRAD_SCALE:   grad_scale_reg   <= pwdata;
                default:          decay_rate_reg   <= decay_rate_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_index_t'(paddr[3:2]))
            REG_DECAY_RATE:   prdata = 32'(decay_rate_reg);
            REG_STABILIZER:   prdata = 32'(stabilizer_reg);
            REG_WEIGHT_DECAY: prdata = 32'(weight_decay_reg);
            REG_GRAD_SCALE:   prdata = grad_scale_reg;
            default:          prdata = '0;
        endcase
    end

    assign rho     = (decay_rate_reg > RATE_ONE) ? RATE_ONE : decay_rate_reg;
    assign rho_inv = RATE_ONE - rho;

    // Clearing pass over the accumulator memory after reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end
        else if (clr_active_reg)
        begin
            clr_addr_reg <= clr_addr_reg + AW'(1);
            if (clr_addr_reg == AW'(DEPTH - 1))
            begin
                clr_active_reg <= 1'b0;
            end
        end
    end

    // Flow control.
    always_comb
    begin
        hazard = 1'b0;
        for (int s = 0; s < NS; s++)
        begin
            if (pipe_valid_reg[s] && (pipe_reg[s].addr == f3_reg.addr))
            begin
                hazard = 1'b1;
            end
        end
    end

    assign block     = f3_valid_reg && hazard;
    assign back_en   = !skid_valid_reg;
    assign front_adv = back_en && !block;
    assign req_ready = !clr_active_reg && front_adv;

    // Address stages: element index modulo DEPTH by reciprocal and one correction.
    always_comb
    begin
        logic [35:0] prod;
        f1_next     = '0;
        prod        = 36'(req_data.elem_index) * 36'(RECIP);
        f1_next.idx = req_data.elem_index;
        f1_next.w   = req_data.weight_in;
        f1_next.grad = req_data.gradient_in;
        f1_next.qd  = IDX_W'(prod >> 24);
    end

    always_comb
    begin
        logic [32:0] qmul;
        f2_next    = f1_reg;
        qmul       = 33'(f1_reg.qd) * 33'(DEPTH);
        f2_next.rr = IDX_W'(33'(f1_reg.idx) - qmul);
    end

    always_comb
    begin
        logic [31:0] r32;
        f3_next = f2_reg;
        r32     = 32'(f2_reg.rr);
        if (r32 >= 32'(DEPTH))
        begin
            r32 = r32 - 32'(DEPTH);
        end
        f3_next.addr = AW'(r32);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_valid_reg <= 1'b0;
            f2_valid_reg <= 1'b0;
            f3_valid_reg <= 1'b0;
        end
        else if (front_adv)
        begin
            f1_valid_reg <= req_valid && req_ready;
            f2_valid_reg <= f1_valid_reg;
            f3_valid_reg <= f2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (front_adv)
        begin
            f1_reg <= f1_next;
            f2_reg <= f2_next;
            f3_reg <= f3_next;
        end
    end

    // Main pipeline.
    assign stage_next[0] = f3_reg;

    for (genvar s = 1; s < NS; s++)
    begin : g_stage
        if (s == P_RD)
        begin : g_rd
            always_comb
            begin
                item_t it;
                logic [31:0] ga;
                logic [31:0] wa;
                it         = pipe_reg[s-1];
                ga         = it.grad[31] ? (32'd0 - it.grad) : it.grad;
                wa         = it.w[31] ? (32'd0 - 32'(it.w)) : 32'(it.w);
                it.sga_old = ram_rdata[63:32];
                it.sda_old = ram_rdata[31:0];
                it.pg      = 64'(ga) * 64'(grad_scale_reg);
                it.wl      = 48'(wa) * 48'(weight_decay_reg);
                stage_next[s] = it;
            end
        end
        else if (s == P_G)
        begin : g_g
            always_comb
            begin
                item_t it;
                logic [63:0] ps;
                logic [31:0] rp;
                it    = pipe_reg[s-1];
                ps    = it.pg >> FRAC_BITS;
                it.gs = it.grad[31];
                if (it.gs)
                begin
                    it.gm = (ps > 64'h8000_0000) ? 32'h8000_0000 : ps[31:0];
                end
                else
                begin
                    it.gm = (ps > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : ps[31:0];
                end
                rp    = 32'(it.wl >> RATE_BITS);
                it.rg = it.w[31] ? -$signed({1'b0, rp}) : $signed({1'b0, rp});
                stage_next[s] = it;
            end
        end
        else if (s == P_G2)
        begin : g_g2
            always_comb
            begin
                item_t it;
                it    = pipe_reg[s-1];
                it.g2 = 64'(it.gm) * 64'(it.gm);
                it.pa = 49'(rho) * 49'(it.sga_old);
                stage_next[s] = it;
            end
        end
        else if (s == P_PB || s == P_PB2)
        begin : g_pb
            always_comb
            begin
                item_t it;
                logic [63:0] t;
                logic [31:0] sq;
                it    = pipe_reg[s-1];
                t     = it.g2 >> FRAC_BITS;
                sq    = (|t[63:32]) ? 32'hFFFF_FFFF : t[31:0];
                it.pb = 49'(rho_inv) * 49'(sq);
                stage_next[s] = it;
            end
        end
        else if (s == P_SGA)
        begin : g_sga
            always_comb
            begin
                item_t it;
                logic [49:0] sum;
                it         = pipe_reg[s-1];
                sum        = 50'(it.pa) + 50'(it.pb);
                it.sga_new = sum[47:16];
                it.rem_d   = RAD_W'(33'(it.sda_old) + 33'(stabilizer_reg)) << FRAC_BITS;
                it.rem_n   = RAD_W'(33'(it.sga_new) + 33'(stabilizer_reg)) << FRAC_BITS;
                it.root_d  = '0;
                it.root_n  = '0;
                stage_next[s] = it;
            end
        end
        else if (s >= P_SQ0 && s < P_NUM)
        begin : g_sqrt
            localparam int I = RW - 1 - (s - P_SQ0);
            always_comb
            begin
                item_t it;
                logic [RAD_W:0] cand_d;
                logic [RAD_W:0] cand_n;
                it     = pipe_reg[s-1];
                cand_d = ((RAD_W+1)'(it.root_d) << (I + 1)) + ((RAD_W+1)'(1) << (2 * I));
                cand_n = ((RAD_W+1)'(it.root_n) << (I + 1)) + ((RAD_W+1)'(1) << (2 * I));
                if ({1'b0, it.rem_d} >= cand_d)
                begin
                    it.rem_d     = it.rem_d - cand_d[RAD_W-1:0];
                    it.root_d[I] = 1'b1;
                end
                if ({1'b0, it.rem_n} >= cand_n)
                begin
                    it.rem_n     = it.rem_n - cand_n[RAD_W-1:0];
                    it.root_n[I] = 1'b1;
                end
                stage_next[s] = it;
            end
        end
        else if (s == P_NUM)
        begin : g_num
            always_comb
            begin
                item_t it;
                it      = pipe_reg[s-1];
                it.num  = NW'(it.gm) * NW'(it.root_d);
                it.zden = (it.root_n == '0);
                stage_next[s] = it;
            end
        end
        else if (s == P_OVF)
        begin : g_ovf
            always_comb
            begin
                item_t it;
                it     = pipe_reg[s-1];
                it.ovf = (it.num[NW-1:32] >= it.root_n);
                it.quo = '0;
                stage_next[s] = it;
            end
        end
        else if (s > P_OVF && s < P_DLT)
        begin : g_div
            localparam int I = P_OVF + 32 - s;
            always_comb
            begin
                item_t it;
                logic [NW-1:0] cand;
                it   = pipe_reg[s-1];
                cand = NW'(it.root_n) << I;
                if (it.num >= cand)
                begin
                    it.num    = it.num - cand;
                    it.quo[I] = 1'b1;
                end
                stage_next[s] = it;
            end
        end
        else if (s == P_DLT)
        begin : g_dlt
            always_comb
            begin
                item_t it;
                logic [31:0] qcap;
                it   = pipe_reg[s-1];
                qcap = (it.ovf || it.quo > 32'h8000_0000) ? 32'h8000_0000 : it.quo;
                it.ds = !it.gs;
                if (it.zden)
                begin
                    it.dm = '0;
                end
                else if (it.gs)
                begin
                    it.dm = (qcap > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : qcap;
                end
                else
                begin
                    it.dm = qcap;
                end
                stage_next[s] = it;
            end
        end
        else if (s == P_D2)
        begin : g_d2
            always_comb
            begin
                item_t it;
                it    = pipe_reg[s-1];
                it.g2 = 64'(it.dm) * 64'(it.dm);
                it.pa = 49'(rho) * 49'(it.sda_old);
                stage_next[s] = it;
            end
        end
        else
        begin : g_fin
            always_comb
            begin
                item_t it;
                logic [49:0]        sum;
                logic signed [32:0] dlt;
                logic signed [34:0] nw;
                it         = pipe_reg[s-1];
                sum        = 50'(it.pa) + 50'(it.pb);
                it.sda_new = sum[47:16];
                dlt        = it.ds ? -$signed({1'b0, it.dm}) : $signed({1'b0, it.dm});
                nw         = 35'(it.w) + 35'(dlt) - 35'(it.rg);
                if (nw > 35'sd2147483647)
                begin
                    it.wout = 32'sh7FFF_FFFF;
                end
                else if (nw < -35'sd2147483648)
                begin
                    it.wout = 32'sh8000_0000;
                end
                else
                begin
                    it.wout = nw[31:0];
                end
                stage_next[s] = it;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pipe_valid_reg <= '0;
        end
        else if (back_en)
        begin
            pipe_valid_reg <= {pipe_valid_reg[NS-2:0], f3_valid_reg && !block};
        end
    end

    always_ff @(posedge clk)
    begin
        if (back_en)
        begin
            for (int s = 0; s < NS; s++)
            begin
                pipe_reg[s] <= stage_next[s];
            end
        end
    end

    // Accumulator memory: both running averages of one element in one word.
    assign push      = back_en && pipe_valid_reg[NS-1];
    assign ram_we    = clr_active_reg || push;
    assign ram_waddr = clr_active_reg ? clr_addr_reg : pipe_reg[NS-1].addr;
    assign ram_wdata = clr_active_reg ? 64'd0
                                      : {pipe_reg[NS-1].sga_new, pipe_reg[NS-1].sda_new};

    adu_ram #(
        .WIDTH (64),
        .DEPTH (DEPTH)
    ) u_acc_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (back_en),
        .raddr (f3_reg.addr),
        .rdata (ram_rdata)
    );

    // Output register with one skid entry.
    assign take                     = rsp_valid_reg && rsp_ready;
    assign push_data.elem_index_out = pipe_reg[NS-1].idx;
    assign push_data.weight_out     = pipe_reg[NS-1].wout;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (take)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (rsp_valid_reg && !take)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                rsp_valid_reg <= 1'b1;
            end
        end
        else if (take)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (take)
            begin
                rsp_data_reg <= skid_data_reg;
            end
        end
        else if (push)
        begin
            if (rsp_valid_reg && !take)
            begin
                skid_data_reg <= push_data;
            end
            else
            begin
                rsp_data_reg <= push_data;
            end
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

    // The memory is never in use by a transaction while it is being cleared.
    a_clear_idle : assert property (@(posedge clk) disable iff (!rst_n)
        clr_active_reg |-> !(|pipe_valid_reg))
        else $error("transaction in flight during memory clear");

    // The skid entry is only ever occupied behind a full output register.
    a_skid_order : assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> rsp_valid_reg)
        else $error("skid entry holds data while output register is empty");

    // A stalled pipeline keeps all of its transactions.
    a_stall_hold : assert property (@(posedge clk) disable iff (!rst_n)
        !back_en |=> $stable(pipe_valid_reg))
        else $error("pipeline valid bits changed during a stall");

    // A transaction leaving the pipeline always becomes visible at the output.
    a_push_out : assert property (@(posedge clk) disable iff (!rst_n)
        push |=> rsp_valid_reg)
        else $error("finished transaction not presented at the output");

endmodule

// ===== rtl/adu_ram.sv =====
// Generic single-write, single-read memory with a registered read port.
module adu_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== tb/tb_adadelta_update.sv =====
// Self-checking testbench for the Adadelta update block with a predictor and random stimulus.
module tb_adadelta_update;
    timeunit 1ns;
    timeprecision 1ps;
    import adu_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 200;

    logic                clk;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;
    logic                req_valid;
    logic                req_ready;
    update_req_t         req_data;
    logic                rsp_valid;
    logic                rsp_ready;
    update_rsp_t         rsp_data;

    adadelta_update uut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
        .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
    );

    logic [16:0] rho_cfg;
    logic [15:0] eps_cfg;
    logic [15:0] lambda_cfg;
    logic [31:0] scale_cfg;
    logic [31:0] grad_acc [DEPTH_DEFAULT];
    logic [31:0] delta_acc [DEPTH_DEFAULT];
    update_rsp_t pending_updates[$];
    int          mismatches;
    int          idle_cycles;
    bit          timed_out;
    bit          fast_mode;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint scaled_product(longint a, logic [63:0] b, int sh);
        logic [63:0] m;
        logic [63:0] p;
        m = (a < 0) ? 64'(-a) : 64'(a);
        p = (m * b) >> sh;
        if (p > 64'h1_0000_0000) p = 64'h1_0000_0000;
        return (a < 0) ? -longint'(p) : longint'(p);
    endfunction

    function automatic logic [31:0] squared_q(longint a);
        logic [63:0] m;
        logic [63:0] p;
        m = (a < 0) ? 64'(-a) : 64'(a);
        p = (m * m) >> FRAC_BITS_DEFAULT;
        return (p > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : p[31:0];
    endfunction

    function automatic logic [31:0] blend(logic [31:0] old, logic [31:0] sample,
                                          logic [16:0] rho);
        logic [63:0] s;
        s = 64'(rho) * 64'(old) + 64'(RATE_ONE - rho) * 64'(sample);
        return s[47:16];
    endfunction

    function automatic logic [63:0] floor_sqrt(logic [63:0] x);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'h1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic update_rsp_t predict_weight(update_req_t t);
        int          idx;
        longint      w;
        longint      g;
        longint      delta;
        longint      decay_term;
        logic [16:0] rho;
        logic [63:0] sd;
        logic [63:0] sn;
        logic [63:0] q;
        update_rsp_t r;
        idx = int'(t.elem_index) % DEPTH_DEFAULT;
        w = longint'(t.weight_in);
        rho = (rho_cfg > RATE_ONE) ? RATE_ONE : rho_cfg;
        g = sat32(scaled_product(longint'(t.gradient_in), 64'(scale_cfg), FRAC_BITS_DEFAULT));
        grad_acc[idx] = blend(grad_acc[idx], squared_q(g), rho);
        sd = floor_sqrt((64'(delta_acc[idx]) + 64'(eps_cfg)) << FRAC_BITS_DEFAULT);
        sn = floor_sqrt((64'(grad_acc[idx]) + 64'(eps_cfg)) << FRAC_BITS_DEFAULT);
        if (sn == 0)
            delta = 0;
        else
        begin
            q = (((g < 0) ? 64'(-g) : 64'(g)) * sd) / sn;
            if (q > 64'h8000_0000) q = 64'h8000_0000;
            delta = sat32((g < 0) ? longint'(q) : -longint'(q));
        end
        delta_acc[idx] = blend(delta_acc[idx], squared_q(delta), rho);
        decay_term = scaled_product(w, 64'(lambda_cfg), RATE_BITS);
        r.elem_index_out = t.elem_index;
        r.weight_out = 32'(sat32(w + delta - decay_term));
        return r;
    endfunction

    task automatic write_register(reg_index_t idx, logic [31:0] value);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= PADDR_W'(4 * int'(idx));
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_DECAY_RATE:   rho_cfg = value[16:0];
            REG_STABILIZER:   eps_cfg = value[15:0];
            REG_WEIGHT_DECAY: lambda_cfg = value[15:0];
            REG_GRAD_SCALE:   scale_cfg = value;
            default:          ;
        endcase
    endtask

    task automatic send_update(logic [11:0] idx, logic [31:0] w, logic [31:0] g);
        int gap;
        update_req_t t;
        gap = fast_mode ? 0 : $urandom_range(0, 14);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        t.elem_index = idx;
        t.weight_in = w;
        t.gradient_in = g;
        req_data <= t;
        req_valid <= 1'b1;
        @(posedge clk);
        while (!req_ready) @(posedge clk);
        pending_updates.insert(pending_updates.size(), predict_weight(t));
        @(negedge clk);
    endtask

    task automatic wait_until_drained();
        req_valid <= 1'b0;
        while (pending_updates.size() != 0 && !timed_out) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic set_config(logic [16:0] rho, logic [15:0] eps, logic [15:0] lam,
                              logic [31:0] sc);
        wait_until_drained();
        write_register(REG_DECAY_RATE, 32'(rho));
        write_register(REG_STABILIZER, 32'(eps));
        write_register(REG_WEIGHT_DECAY, 32'(lam));
        write_register(REG_GRAD_SCALE, sc);
    endtask

    function automatic logic [31:0] random_word();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'($signed($urandom_range(0, 131072)) - 65536);
            3: return 32'($signed($urandom_range(0, 2048)) - 1024) << 8;
            default: return $urandom;
        endcase
    endfunction

    task automatic test_field_extremes();
        send_update(12'd0, 32'h0001_0000, 32'h0000_8000);
        send_update(12'hFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_update(12'hFFF, 32'h8000_0000, 32'h8000_0000);
        send_update(12'd1, 32'h8000_0000, 32'h7FFF_FFFF);
        send_update(12'd2, 32'h7FFF_FFFF, 32'h8000_0000);
        send_update(12'd3, 32'h0, 32'h0);
        send_update(12'hAAA, 32'h5555_5555, 32'hAAAA_AAAA);
        send_update(12'h555, 32'hAAAA_AAAA, 32'h5555_5555);
    endtask

    task automatic test_repeated_element();
        repeat (6) send_update(12'd7, 32'h0002_0000, 32'hFFFF_0000);
    endtask

    task automatic test_config_extremes();
        set_config(17'h1FFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
        send_update(12'd10, 32'h0001_0000, 32'h0000_0100);
        send_update(12'd10, 32'h8000_0000, 32'h8000_0000);
        set_config(17'd0, 16'd0, 16'd0, 32'd0);
        send_update(12'd11, 32'h0001_0000, 32'h0001_0000);
        send_update(12'd11, 32'h1234_5678, 32'hFFFF_FFFF);
        set_config(17'd65536, 16'd0, 16'd32768, 32'h0000_8000);
        send_update(12'd12, 32'h7FFF_FFFF, 32'h0003_0000);
        send_update(12'd13, 32'hFFFF_0000, 32'h0);
    endtask

    task automatic test_random_updates(int count);
        for (int i = 0; i < count; i++)
        begin
            if (i % 300 == 0)
                set_config($urandom_range(0, 17'h1FFFF), $urandom_range(0, 65535),
                           $urandom_range(0, 65535),
                           ($urandom_range(0, 3) == 0) ? $urandom
                                                       : $urandom_range(0, 32'h0004_0000));
            fast_mode = ($urandom_range(0, 3) == 0);
            send_update(($urandom_range(0, 1) == 0) ? 12'($urandom_range(0, 15))
                                                    : 12'($urandom),
                        random_word(), random_word());
        end
        fast_mode = 1'b0;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (pending_updates.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected transaction: index %0h weight %0h",
                             rsp_data.elem_index_out, rsp_data.weight_out);
            end
            else
            begin
                update_rsp_t e;
                e = pending_updates.pop_front();
                if (e.elem_index_out !== rsp_data.elem_index_out ||
                    e.weight_out !== rsp_data.weight_out)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected index %0h weight %0h, got %0h %0h",
                                 e.elem_index_out, e.weight_out,
                                 rsp_data.elem_index_out, rsp_data.weight_out);
                end
            end
        end
    end

    initial
    begin
        int stall;
        stall = 0;
        forever
        begin
            @(negedge clk);
            if (stall > 0)
            begin
                rsp_ready <= 1'b0;
                stall--;
            end
            else if (fast_mode)
                rsp_ready <= 1'b1;
            else
            begin
                stall = $urandom_range(0, 14);
                rsp_ready <= (stall == 0);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT && !timed_out)
        begin
            timed_out = 1'b1;
            $display("adadelta_update verification failed");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        req_valid = 1'b0;
        req_data = '0;
        rsp_ready = 1'b0;
        mismatches = 0;
        idle_cycles = 0;
        timed_out = 1'b0;
        fast_mode = 1'b0;
        rho_cfg = DECAY_RATE_RESET;
        eps_cfg = STABILIZER_RESET;
        lambda_cfg = WEIGHT_DECAY_RESET;
        scale_cfg = GRAD_SCALE_RESET;
        foreach (grad_acc[i])
        begin
            grad_acc[i] = '0;
            delta_acc[i] = '0;
        end
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        test_field_extremes();
        test_repeated_element();
        test_config_extremes();
        set_config(DECAY_RATE_RESET, STABILIZER_RESET, 16'd655, GRAD_SCALE_RESET);
        test_random_updates(1500);
        wait_until_drained();
        if (mismatches == 0 && pending_updates.size() == 0)
            $display("adadelta_update verification clean");
        else
            $display("adadelta_update verification failed");
        $finish;
    end
endmodule
